@@ rtl/bsmmg_pkg.sv @@
package bsmmg_pkg;

   localparam int unsigned MaxEntries = 256;
   localparam int unsigned AddrWidth  = $clog2(MaxEntries);
   localparam int unsigned CountWidth = AddrWidth + 1;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned FieldWidth = 9;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FULL    = 2'd1;
   localparam logic [1:0] STATUS_BAD_POS = 2'd2;

   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

@@ rtl/bounded_set_min_max_gap.sv @@
// Bounded multiset of signed 32-bit values reporting the smallest gap between
// sorted neighbors and the full range (largest minus smallest). Values live
// unordered in a 256 x 32 single-port-style memory with a registered read.
// One request is processed at a time. A rejected request or an empty run goes
// straight to the response. An accepted request scans every stored entry
// through the memory read port, one entry per cycle, to find the new value's
// nearest neighbor, then writes its copies one per cycle (run length 1 for an
// append). The first value into an empty set skips the scan. A finished
// response is held in an output register, so the next request is taken while
// it waits. csr_wr_data sets the capacity and should be written only while
// the block is idle.
module bounded_set_min_max_gap (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data,   // capacity
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,     // value[31:0], position[40:32], copies[49:41]
   input  logic        req_tuser,     // mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata      // status[1:0], span_valid[2],
                                      // shortest_span[34:3], longest_span[66:35]
);

   localparam int unsigned AW = bsmmg_pkg::AddrWidth;
   localparam int unsigned CW = bsmmg_pkg::CountWidth;
   localparam int unsigned VW = bsmmg_pkg::ValueWidth;
   localparam int unsigned FW = bsmmg_pkg::FieldWidth;
   localparam int unsigned SW = ((CW > FW) ? CW : FW) + 1;

   bsmmg_pkg::state_type state_ff, state_in;

   logic [FW-1:0] capacity_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [VW-1:0] smallest_ff, smallest_in;
   logic [VW-1:0] largest_ff, largest_in;
   logic [VW-1:0] min_gap_ff, min_gap_in;
   logic [VW-1:0] best_ff, best_in;
   logic [VW-1:0] value_ff, value_in;
   logic [FW-1:0] remain_ff, remain_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [1:0]    status_ff, status_in;
   logic          run_ff, run_in;
   logic          rd_vld_ff;
   logic [VW-1:0] rd_data_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [71:0]   rsp_data_ff, rsp_data_in;

   logic [VW-1:0] mem [bsmmg_pkg::MaxEntries];

   logic          req_accept;
   logic          rd_en;
   logic          wr_en;
   logic          rsp_load;
   logic          req_mode;
   logic [VW-1:0] req_value;
   logic [FW-1:0] req_position;
   logic [FW-1:0] req_copies;
   logic [FW-1:0] req_n;
   logic [SW-1:0] run_end;
   logic [1:0]    req_status;
   logic [VW:0]   diff;
   logic [VW:0]   abs_diff;
   logic          span_ok;

   assign req_mode     = req_tuser;
   assign req_value    = req_tdata[31:0];
   assign req_position = req_tdata[40:32];
   assign req_copies   = req_tdata[49:41];
   assign req_accept   = req_tvalid && req_tready;
   assign req_n        = (req_mode == bsmmg_pkg::MODE_INSERT) ? req_copies : FW'(1);
   assign run_end      = SW'(count_ff) + SW'(req_copies);

   always_comb begin
      req_status = bsmmg_pkg::STATUS_OK;
      if (req_mode == bsmmg_pkg::MODE_APPEND) begin
         if (capacity_ff == '0 || SW'(count_ff) >= SW'(capacity_ff) ||
             SW'(count_ff) >= SW'(bsmmg_pkg::MaxEntries)) begin
            req_status = bsmmg_pkg::STATUS_FULL;
         end
      end else begin
         if (SW'(req_position) > SW'(count_ff) || capacity_ff == '0) begin
            req_status = bsmmg_pkg::STATUS_BAD_POS;
         end else if (run_end > SW'(capacity_ff) ||
                      run_end > SW'(bsmmg_pkg::MaxEntries) ||
                      req_position > capacity_ff) begin
            req_status = bsmmg_pkg::STATUS_FULL;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsmmg_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_status != bsmmg_pkg::STATUS_OK || req_n == '0) begin
                  state_in = bsmmg_pkg::ST_DONE;
               end else if (count_ff == '0) begin
                  state_in = bsmmg_pkg::ST_UPDATE;
               end else begin
                  state_in = bsmmg_pkg::ST_SCAN;
               end
            end
         end
         bsmmg_pkg::ST_SCAN: begin
            if (scan_ff == count_ff - CW'(1)) begin
               state_in = bsmmg_pkg::ST_DRAIN;
            end
         end
         bsmmg_pkg::ST_DRAIN:  state_in = bsmmg_pkg::ST_UPDATE;
         bsmmg_pkg::ST_UPDATE: state_in = bsmmg_pkg::ST_WRITE;
         bsmmg_pkg::ST_WRITE: begin
            if (remain_ff == FW'(1)) begin
               state_in = bsmmg_pkg::ST_DONE;
            end
         end
         bsmmg_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = bsmmg_pkg::ST_IDLE;
            end
         end
         default: state_in = bsmmg_pkg::ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         bsmmg_pkg::ST_IDLE:  req_tready = 1'b1;
         bsmmg_pkg::ST_SCAN:  rd_en      = 1'b1;
         bsmmg_pkg::ST_WRITE: wr_en      = 1'b1;
         bsmmg_pkg::ST_DONE:  rsp_load   = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign diff     = {rd_data_ff[VW-1], rd_data_ff} - {value_ff[VW-1], value_ff};
   assign abs_diff = diff[VW] ? (~diff + (VW+1)'(1)) : diff;
   assign span_ok  = count_ff >= CW'(2);

   // datapath
   always_comb begin
      count_in    = count_ff;
      smallest_in = smallest_ff;
      largest_in  = largest_ff;
      min_gap_in  = min_gap_ff;
      best_in     = best_ff;
      value_in    = value_ff;
      remain_in   = remain_ff;
      scan_in     = scan_ff;
      status_in   = status_ff;
      run_in      = run_ff;

      if (req_accept) begin
         value_in  = req_value;
         remain_in = req_n;
         status_in = req_status;
         run_in    = req_n >= FW'(2);
         scan_in   = '0;
         best_in   = '1;
      end

      if (rd_en) begin
         scan_in = scan_ff + CW'(1);
      end

      if (rd_vld_ff && abs_diff[VW-1:0] < best_ff) begin
         best_in = abs_diff[VW-1:0];
      end

      if (state_ff == bsmmg_pkg::ST_UPDATE) begin
         if (count_ff == '0) begin
            smallest_in = value_ff;
            largest_in  = value_ff;
         end else begin
            if (best_ff < min_gap_ff) begin
               min_gap_in = best_ff;
            end
            if ($signed(value_ff) < $signed(smallest_ff)) begin
               smallest_in = value_ff;
            end
            if ($signed(value_ff) > $signed(largest_ff)) begin
               largest_in = value_ff;
            end
         end
         if (run_ff) begin
            min_gap_in = '0;
         end
      end

      if (wr_en) begin
         count_in  = count_ff + CW'(1);
         remain_in = remain_ff - FW'(1);
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in = '0;
         rsp_data_in[1:0]   = status_ff;
         rsp_data_in[2]     = span_ok;
         rsp_data_in[34:3]  = span_ok ? min_gap_ff : '1;
         rsp_data_in[66:35] = span_ok ? (largest_ff - smallest_ff) : '0;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= value_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[scan_ff[AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsmmg_pkg::ST_IDLE;
         capacity_ff  <= '0;
         count_ff     <= '0;
         smallest_ff  <= '0;
         largest_ff   <= '0;
         min_gap_ff   <= '1;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         smallest_ff  <= smallest_in;
         largest_ff   <= largest_in;
         min_gap_ff   <= min_gap_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff     <= best_in;
      value_ff    <= value_in;
      remain_ff   <= remain_in;
      scan_ff     <= scan_in;
      status_ff   <= status_in;
      run_ff      <= run_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
